// File: rtl/htlp_pkg.sv
// Package for the linear-probing hash table insert block.
// Holds shared constants, code values and state types; no dependencies.
package htlp_pkg;

    localparam int DEF_DEPTH      = 16;
    localparam int DEF_KEY_BITS   = 34;
    localparam int DEF_VALUE_BITS = 32;

    localparam int TABLE_SIZE_W = 5;
    localparam int SLOT_W       = 4;
    localparam int SLOT_COUNT   = 2 ** SLOT_W;
    localparam int STATUS_W     = 2;
    localparam int PROBES_W     = 5;

    localparam logic [TABLE_SIZE_W-1:0] TABLE_SIZE_RESET = 5'd10;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam logic [STATUS_W-1:0] ST_HOME    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PROBED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_READ    = 2'd3;

    // Classification of a queued item.
    typedef enum logic [1:0] {
        CLS_READ,
        CLS_DROP,
        CLS_INSERT
    } t_cls;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_READ,
        B_PROBE
    } t_back_state;

endpackage

// File: rtl/htlp_if.sv
// Handshake interfaces for the hash table block: request, result and config channels.
// Depends on htlp_pkg for the fixed field widths.
interface htlp_req_if
    import htlp_pkg::*;
#(
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
);
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [SLOT_W-1:0]     slot;

    modport source (output valid, op, key, value, slot, input ready);
    modport sink   (input valid, op, key, value, slot, output ready);
endinterface

interface htlp_res_if
    import htlp_pkg::*;
#(
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
);
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_W-1:0]     where;
    logic [PROBES_W-1:0]   probes;
    logic [KEY_BITS-1:0]   slot_key;
    logic [VALUE_BITS-1:0] slot_value;

    modport source (output valid, status, where, probes, slot_key, slot_value, input ready);
    modport sink   (input valid, status, where, probes, slot_key, slot_value, output ready);
endinterface

interface htlp_cfg_if
    import htlp_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [TABLE_SIZE_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: rtl/htlp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module htlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/htlp_queue.sv
// Two-entry flop queue between the front and back parts of the hash table block.
// No dependencies.
module htlp_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_data [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wp] <= i_data;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_data[r_rp];

endmodule

// File: rtl/htlp_front.sv
// Front part: accepts requests, classifies them and computes the home slot
// as key modulo table size, one key bit per cycle. Depends on htlp_pkg, htlp_if.
module htlp_front
    import htlp_pkg::*;
#(
    parameter int DEPTH      = DEF_DEPTH,
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int QW         = 2 + $clog2(DEPTH) + KEY_BITS + VALUE_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    htlp_req_if.sink                i_req,
    input  logic [TABLE_SIZE_W-1:0] i_eff_size,
    input  logic                    i_clr_busy,
    output logic                    o_push,
    output logic [QW-1:0]           o_entry,
    input  logic                    i_full
);

    localparam int AW = $clog2(DEPTH);
    localparam int BW = $clog2(KEY_BITS);

    t_front_state r_state, n_state;

    t_cls                    r_cls, n_cls;
    logic [AW-1:0]           r_addr, n_addr;
    logic [KEY_BITS-1:0]     r_key, n_key;
    logic [VALUE_BITS-1:0]   r_value, n_value;
    logic [TABLE_SIZE_W-1:0] r_rem, n_rem;
    logic [BW-1:0]           r_bit, n_bit;

    logic [AW-1:0]           slot_map [SLOT_COUNT];
    logic [TABLE_SIZE_W:0]   rem_shift;
    logic [TABLE_SIZE_W-1:0] rem_step;

    // Read slots wrap modulo the memory depth; the map is fixed at elaboration.
    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_slot_map
        assign slot_map[g] = AW'(g % DEPTH);
    end

    // Restoring remainder step: the remainder stays below the size, so one
    // conditional subtract is enough.
    always_comb begin
        rem_shift = {r_rem, r_key[r_bit]};
        if (rem_shift >= {1'b0, i_eff_size}) begin
            rem_step = TABLE_SIZE_W'(rem_shift - {1'b0, i_eff_size});
        end else begin
            rem_step = rem_shift[TABLE_SIZE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cls   <= n_cls;
        r_addr  <= n_addr;
        r_key   <= n_key;
        r_value <= n_value;
        r_rem   <= n_rem;
        r_bit   <= n_bit;
    end

    always_comb begin
        n_state     = r_state;
        n_cls       = r_cls;
        n_addr      = r_addr;
        n_key       = r_key;
        n_value     = r_value;
        n_rem       = r_rem;
        n_bit       = r_bit;
        i_req.ready = 1'b0;
        o_push      = 1'b0;

        case (r_state)
            F_IDLE: begin
                i_req.ready = !i_clr_busy;
                if (i_req.valid && !i_clr_busy) begin
                    n_key   = i_req.key;
                    n_value = i_req.value;
                    n_addr  = slot_map[i_req.slot];
                    n_rem   = '0;
                    n_bit   = BW'(KEY_BITS - 1);
                    if (i_req.op == OP_READ) begin
                        n_cls   = CLS_READ;
                        n_state = F_PUSH;
                    end else if (i_req.key == '0) begin
                        n_cls   = CLS_DROP;
                        n_state = F_PUSH;
                    end else begin
                        n_cls   = CLS_INSERT;
                        n_state = F_DIV;
                    end
                end
            end
            F_DIV: begin
                n_rem = rem_step;
                n_bit = r_bit - 1'b1;
                if (r_bit == '0) begin
                    n_addr  = AW'(rem_step);
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    assign o_entry = {r_cls, r_addr, r_key, r_value};

endmodule

// File: rtl/htlp_back.sv
// Back part: clears the slot memory after reset, then carries out reads and
// linear-probe inserts and holds the result register. Depends on htlp_pkg,
// htlp_if and htlp_ram.
module htlp_back
    import htlp_pkg::*;
#(
    parameter int DEPTH      = DEF_DEPTH,
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int QW         = 2 + $clog2(DEPTH) + KEY_BITS + VALUE_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [TABLE_SIZE_W-1:0] i_eff_size,
    output logic                    o_clr_busy,
    input  logic [QW-1:0]           i_entry,
    input  logic                    i_empty,
    output logic                    o_pop,
    htlp_res_if.source              o_res
);

    localparam int AW = $clog2(DEPTH);
    localparam int RW = KEY_BITS + VALUE_BITS;

    t_back_state r_state, n_state;

    logic [AW-1:0]           r_clr_addr, n_clr_addr;
    logic [AW-1:0]           r_idx, n_idx;
    logic [AW-1:0]           r_home, n_home;
    logic [PROBES_W-1:0]     r_count, n_count;
    logic [KEY_BITS-1:0]     r_key, n_key;
    logic [VALUE_BITS-1:0]   r_val, n_val;

    logic                    r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]     r_status, n_status;
    logic [SLOT_W-1:0]       r_where, n_where;
    logic [PROBES_W-1:0]     r_probes, n_probes;
    logic [KEY_BITS-1:0]     r_okey, n_okey;
    logic [VALUE_BITS-1:0]   r_oval, n_oval;

    logic                    we;
    logic [AW-1:0]           waddr;
    logic [RW-1:0]           wdata;
    logic [AW-1:0]           raddr;
    logic [RW-1:0]           rdata;
    logic [KEY_BITS-1:0]     rd_key;
    logic [VALUE_BITS-1:0]   rd_val;
    logic [AW-1:0]           nxt;

    t_cls                    e_cls;
    logic [AW-1:0]           e_addr;
    logic [KEY_BITS-1:0]     e_key;
    logic [VALUE_BITS-1:0]   e_val;

    htlp_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rd_key = rdata[RW-1:VALUE_BITS];
    assign rd_val = rdata[VALUE_BITS-1:0];

    assign e_cls  = t_cls'(i_entry[QW-1:QW-2]);
    assign e_addr = i_entry[QW-3:RW];
    assign e_key  = i_entry[RW-1:VALUE_BITS];
    assign e_val  = i_entry[VALUE_BITS-1:0];

    // Next probe position, wrapping at the effective table size.
    assign nxt = ((32'(r_idx) + 1) == 32'(i_eff_size)) ? '0 : r_idx + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_home   <= n_home;
        r_count  <= n_count;
        r_key    <= n_key;
        r_val    <= n_val;
        r_status <= n_status;
        r_where  <= n_where;
        r_probes <= n_probes;
        r_okey   <= n_okey;
        r_oval   <= n_oval;
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_idx       = r_idx;
        n_home      = r_home;
        n_count     = r_count;
        n_key       = r_key;
        n_val       = r_val;
        n_out_valid = r_out_valid && !o_res.ready;
        n_status    = r_status;
        n_where     = r_where;
        n_probes    = r_probes;
        n_okey      = r_okey;
        n_oval      = r_oval;
        we          = 1'b0;
        waddr       = r_idx;
        wdata       = {r_key, r_val};
        raddr       = r_idx;
        o_pop       = 1'b0;

        case (r_state)
            B_CLEAR: begin
                we         = 1'b1;
                waddr      = r_clr_addr;
                wdata      = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                // Only one item is in flight here, so an empty result register
                // at pop time stays free until that item finishes.
                if (!i_empty && !r_out_valid) begin
                    o_pop   = 1'b1;
                    n_key   = e_key;
                    n_val   = e_val;
                    n_home  = e_addr;
                    n_idx   = e_addr;
                    n_count = '0;
                    raddr   = e_addr;
                    case (e_cls)
                        CLS_READ:   n_state = B_READ;
                        CLS_INSERT: n_state = B_PROBE;
                        default: begin
                            n_out_valid = 1'b1;
                            n_status    = ST_DROPPED;
                            n_where     = '0;
                            n_probes    = '0;
                            n_okey      = '0;
                            n_oval      = '0;
                        end
                    endcase
                end
            end
            B_READ: begin
                n_out_valid = 1'b1;
                n_status    = ST_READ;
                n_where     = SLOT_W'(r_idx);
                n_probes    = '0;
                n_okey      = rd_key;
                n_oval      = rd_val;
                n_state     = B_IDLE;
            end
            B_PROBE: begin
                if (rd_key == '0) begin
                    we          = 1'b1;
                    n_out_valid = 1'b1;
                    n_status    = (r_count == '0) ? ST_HOME : ST_PROBED;
                    n_where     = SLOT_W'(r_idx);
                    n_probes    = r_count;
                    n_okey      = r_key;
                    n_oval      = r_val;
                    n_state     = B_IDLE;
                end else if (nxt == r_home) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_DROPPED;
                    n_where     = SLOT_W'(r_home);
                    n_probes    = PROBES_W'(i_eff_size - 1'b1);
                    n_okey      = '0;
                    n_oval      = '0;
                    n_state     = B_IDLE;
                end else begin
                    n_idx   = nxt;
                    n_count = r_count + 1'b1;
                    raddr   = nxt;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    assign o_clr_busy       = (r_state == B_CLEAR);
    assign o_res.valid      = r_out_valid;
    assign o_res.status     = r_status;
    assign o_res.where      = r_where;
    assign o_res.probes     = r_probes;
    assign o_res.slot_key   = r_okey;
    assign o_res.slot_value = r_oval;

endmodule

// File: rtl/hash_table_linear_probe_insert.sv
// Top level of the open-addressing hash table with linear-probe insert.
// Depends on htlp_pkg, htlp_if, htlp_front, htlp_queue, htlp_back.
//
//   Port    Dir   Moves                               Payload
//   i_req   in    one request transaction             op, key, value, slot
//   o_res   out   one result transaction per request  status, where, probes,
//                                                     slot_key, slot_value
//   i_cfg   in    table_size register write           data
//
// An insert passes through the bit-serial remainder unit in the front, then
// probes in the back, one slot memory read per probe. A read and a zero-key
// drop skip the remainder unit and go from request acceptance to the queue.
// After reset a clearing pass zeroes all DEPTH slots of the memory; no
// request is taken meanwhile, config writes are. A two-entry queue lets the
// front accept and classify while the back probes or a result is stalled.
module hash_table_linear_probe_insert
    import htlp_pkg::*;
#(
    parameter int DEPTH      = DEF_DEPTH,
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    htlp_req_if.sink   i_req,
    htlp_res_if.source o_res,
    htlp_cfg_if.sink   i_cfg
);

    localparam int QW = 2 + $clog2(DEPTH) + KEY_BITS + VALUE_BITS;

    logic [TABLE_SIZE_W-1:0] r_table_size;
    logic [TABLE_SIZE_W-1:0] eff_size;
    logic                    clr_busy;
    logic                    q_push;
    logic                    q_pop;
    logic                    q_full;
    logic                    q_empty;
    logic [QW-1:0]           q_in;
    logic [QW-1:0]           q_out;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= TABLE_SIZE_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_table_size <= i_cfg.data;
        end
    end

    // A size of zero acts as one, and one above the depth acts as the depth.
    always_comb begin
        if (r_table_size == '0) begin
            eff_size = TABLE_SIZE_W'(1);
        end else if (32'(r_table_size) > DEPTH) begin
            eff_size = TABLE_SIZE_W'(DEPTH);
        end else begin
            eff_size = r_table_size;
        end
    end

    htlp_front #(
        .DEPTH      (DEPTH),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS),
        .QW         (QW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_eff_size (eff_size),
        .i_clr_busy (clr_busy),
        .o_push     (q_push),
        .o_entry    (q_in),
        .i_full     (q_full)
    );

    htlp_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    htlp_back #(
        .DEPTH      (DEPTH),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS),
        .QW         (QW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_eff_size (eff_size),
        .o_clr_busy (clr_busy),
        .i_entry    (q_out),
        .i_empty    (q_empty),
        .o_pop      (q_pop),
        .o_res      (o_res)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue pushed while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> !(i_req.valid && i_req.ready))
        else $error("request accepted during memory clearing");

    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status == ST_DROPPED) |->
            (o_res.slot_key == '0 && o_res.slot_value == '0))
        else $error("dropped insert reports nonzero slot contents");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for hash_table_linear_probe_insert: drives random and directed
// inserts and slot reads, and checks each result against a shadow copy of the slot table.
// Depends on htlp_pkg, the htlp_if interfaces and the RTL of the block.
module tb_top;
    import htlp_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int KEY_W          = DEF_KEY_BITS;
    localparam int VAL_W          = DEF_VALUE_BITS;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   where;
        logic [PROBES_W-1:0] probes;
        logic [KEY_W-1:0]    slot_key;
        logic [VAL_W-1:0]    slot_value;
    } t_slot_report;

    logic i_clk = 1'b0;
    logic i_rst_n;

    htlp_req_if req_if ();
    htlp_res_if res_if ();
    htlp_cfg_if cfg_if ();

    hash_table_linear_probe_insert u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Shadow of the slot table and of the table_size register.
    logic [KEY_W-1:0]        shadow_keys   [DEF_DEPTH];
    logic [VAL_W-1:0]        shadow_values [DEF_DEPTH];
    logic [TABLE_SIZE_W-1:0] shadow_size;

    t_slot_report due_reports[$];
    int           mismatch_count = 0;
    bit           idle_on        = 1'b1;
    int           stall_left     = 0;

    // Applies one request to the shadow table and returns the result it must produce.
    function automatic t_slot_report probe_table(logic op, logic [KEY_W-1:0] key,
                                                 logic [VAL_W-1:0] value,
                                                 logic [SLOT_W-1:0] slot);
        t_slot_report r;
        int unsigned  m;
        int unsigned  home;
        int unsigned  idx;
        int unsigned  count;
        r = '0;
        if (shadow_size == 0) begin
            m = 1;
        end else if (shadow_size > DEF_DEPTH) begin
            m = DEF_DEPTH;
        end else begin
            m = 32'(shadow_size);
        end
        if (op == OP_READ) begin
            r.status     = ST_READ;
            r.where      = slot;
            r.slot_key   = shadow_keys[slot];
            r.slot_value = shadow_values[slot];
            return r;
        end
        // A zero key would look like an empty slot, so it is never stored.
        if (key == '0) begin
            r.status = ST_DROPPED;
            return r;
        end
        home  = 32'(key % m);
        idx   = home;
        count = 0;
        while (shadow_keys[idx] != '0) begin
            idx = (idx + 1 == m) ? 0 : idx + 1;
            if (idx == home) begin
                r.status = ST_DROPPED;
                r.where  = SLOT_W'(home);
                r.probes = PROBES_W'(m - 1);
                return r;
            end
            count++;
        end
        shadow_keys[idx]   = key;
        shadow_values[idx] = value;
        r.status     = (count == 0) ? ST_HOME : ST_PROBED;
        r.where      = SLOT_W'(idx);
        r.probes     = PROBES_W'(count);
        r.slot_key   = key;
        r.slot_value = value;
        return r;
    endfunction

    task automatic log_mismatch(string what, t_slot_report want, t_slot_report seen);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s: expected status=%0d where=%0d probes=%0d key=%h value=%h",
                     $time, what, want.status, want.where, want.probes, want.slot_key,
                     want.slot_value);
            $display("%0t: %s:      got status=%0d where=%0d probes=%0d key=%h value=%h",
                     $time, what, seen.status, seen.where, seen.probes, seen.slot_key,
                     seen.slot_value);
        end
    endtask

    // Sends one request transaction and records its expected result on acceptance.
    // Starts and ends at a falling edge; valid stays high for a following request.
    task automatic send_request(logic op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value,
                                logic [SLOT_W-1:0] slot);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.op    <= op;
        req_if.key   <= key;
        req_if.value <= value;
        req_if.slot  <= slot;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        due_reports.push_back(probe_table(op, key, value, slot));
        @(negedge i_clk);
    endtask

    task automatic await_reports_done();
        req_if.valid <= 1'b0;
        while (due_reports.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_table_size(logic [TABLE_SIZE_W-1:0] size);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= size;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        shadow_size = size;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // The receiver stalls in bursts of random length while idle_on is set.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            res_if.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_slot_report seen;
        t_slot_report want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            seen = '{res_if.status, res_if.where, res_if.probes, res_if.slot_key,
                     res_if.slot_value};
            if (due_reports.size() == 0) begin
                log_mismatch("result with nothing pending", '0, seen);
            end else begin
                want = due_reports.pop_front();
                if (seen.status !== want.status || seen.where !== want.where
                        || seen.probes !== want.probes || seen.slot_key !== want.slot_key
                        || seen.slot_value !== want.slot_value) begin
                    log_mismatch("mismatch", want, seen);
                end
            end
        end
    end

    // Runs with the reset table size of ten: home slots, probing, wrap and reads.
    task automatic test_reset_size_inserts();
        send_request(OP_INSERT, '0, 32'hFFFF_FFFF, 4'd15);
        send_request(OP_INSERT, 34'd3, 32'h0, 4'd15);
        send_request(OP_INSERT, 34'd13, 32'hFFFF_FFFF, 4'd0);
        send_request(OP_INSERT, 34'h3_FFFF_FFFF, 32'h5A5A_A5A5, 4'd7);
        send_request(OP_INSERT, 34'd9, 32'h1234_5678, 4'd0);
        send_request(OP_INSERT, 34'd19, 32'h8000_0001, 4'd0);
        send_request(OP_READ, 34'h3_FFFF_FFFF, 32'hFFFF_FFFF, 4'd3);
        send_request(OP_READ, '0, '0, 4'd0);
        send_request(OP_READ, '0, '0, 4'd15);
        send_request(OP_READ, '0, '0, 4'd4);
        await_reports_done();
    endtask

    // Table sizes at and beyond both ends of the range, and full tables.
    task automatic test_size_limits();
        write_table_size(5'd0);
        send_request(OP_INSERT, 34'd7, 32'hCAFE_0001, 4'd0);
        await_reports_done();
        write_table_size(5'd31);
        send_request(OP_INSERT, 34'd16, 32'h0000_0016, 4'd0);
        send_request(OP_INSERT, 34'd15, 32'h0000_0015, 4'd0);
        send_request(OP_INSERT, 34'd31, 32'h0000_0031, 4'd0);
        await_reports_done();
        write_table_size(5'd1);
        send_request(OP_INSERT, 34'd5, 32'h0000_0005, 4'd0);
        await_reports_done();
        write_table_size(5'd17);
        send_request(OP_INSERT, 34'h2_0000_0000, 32'hFFFF_0000, 4'd0);
        await_reports_done();
        write_table_size(5'd16);
        send_request(OP_READ, '0, '0, 4'd15);
        await_reports_done();
        write_table_size(5'd2);
        send_request(OP_INSERT, 34'd1, 32'h0000_0001, 4'd0);
        await_reports_done();
    endtask

    task automatic drive_random_ops(int items, bit pause_midway);
        logic [KEY_W-1:0] key;
        int               roll;
        for (int i = 0; i < items; i++) begin
            // The sender holds off once until every pending result has come back.
            if (pause_midway && i == items / 2) await_reports_done();
            roll = $urandom_range(0, 9);
            key  = {2'($urandom_range(0, 3)), 32'($urandom())};
            if (roll < 4) begin
                send_request(OP_READ, key, $urandom(), 4'($urandom_range(0, 15)));
            end else begin
                if (roll == 4) begin
                    key = '0;
                end else if (roll >= 8) begin
                    key = KEY_W'($urandom_range(1, 40));
                end else if (key == '0) begin
                    key = 34'd1;
                end
                send_request(OP_INSERT, key, $urandom(), 4'($urandom_range(0, 15)));
            end
        end
        await_reports_done();
    endtask

    task automatic test_random_traffic();
        logic [TABLE_SIZE_W-1:0] sizes[8] = '{5'd3, 5'd8, 5'd0, 5'd12, 5'd31, 5'd16,
                                              5'd17, 5'd1};
        foreach (sizes[p]) begin
            write_table_size(sizes[p]);
            drive_random_ops(220, p == 3);
        end
    endtask

    // Final stretch with neither the sender nor the receiver pausing on its own.
    task automatic test_quiet_tail();
        idle_on = 1'b0;
        write_table_size(5'($urandom_range(1, 16)));
        drive_random_ops(220, 1'b0);
    endtask

    initial begin
        for (int i = 0; i < DEF_DEPTH; i++) begin
            shadow_keys[i]   = '0;
            shadow_values[i] = '0;
        end
        shadow_size  = TABLE_SIZE_RESET;
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.op    = OP_INSERT;
        req_if.key   = '0;
        req_if.value = '0;
        req_if.slot  = '0;
        res_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_size_inserts();
        test_size_limits();
        test_random_traffic();
        test_quiet_tail();
        await_reports_done();

        if (mismatch_count == 0 && due_reports.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
rtl/htlp_pkg.sv
rtl/htlp_if.sv
rtl/htlp_ram.sv
rtl/htlp_queue.sv
rtl/htlp_front.sv
rtl/htlp_back.sv
rtl/hash_table_linear_probe_insert.sv
tb/sv/tb_top.sv
